/* rtl/assert_macros.svh */
// Assertion helpers used by the queue unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge, including edges in reset.
`define SPQ_ASSERT(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
    else $error("spq assertion failed");

// Checked only while the active-low reset is released.
`define SPQ_ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("spq assertion failed");

`endif

/* rtl/spq_pkg.sv */
`default_nettype none

package spq_pkg;

    // Default sizes
    localparam int DEPTH_DEF         = 32;
    localparam int PAYLOAD_BITS_DEF  = 32;
    localparam int PRIORITY_BITS_DEF = 16;

    // Fixed field widths
    localparam int CMD_W      = 2;
    localparam int PAY_PORT_W = 32;
    localparam int PRI_PORT_W = 16;
    localparam int CNT_W      = 6;
    localparam int STAT_W     = 2;

    localparam logic [CNT_W-1:0] LIMIT_RESET = 6'd32;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_DEQUEUE = 2'd1,
        CMD_CLEAR   = 2'd2
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Shift control broadcast to every cell
    typedef struct packed {
        logic enq;  // insert new request, shift lower entries down
        logic deq;  // shift all entries toward the head
    } t_cell_ctrl;

endpackage

`default_nettype wire

/* rtl/sorted_priority_queue_unit.sv */
`default_nettype none
// Channel   Direction  Handshake          Fields
// request   in         start & !busy      i_command, i_payload, i_priority_req
// result    out        o_strobe (1 cycle) o_out_payload, o_status, o_item_count,
//                                         o_is_empty, o_is_full
// config    in         i_cfg_we           i_cfg_wdata (capacity limit)
//
// One request per cycle; its result is registered and on the outputs in the
// cycle after accept. All cells compare against the new priority and shift in
// the same cycle, so that parallel compare sets the rate; busy is always low.
// Synchronous active-low reset empties the queue and sets the limit to 32;
// entry contents are not cleared. The receiver cannot stall the result.

`include "assert_macros.svh"

module sorted_priority_queue_unit #(
    parameter int DEPTH         = spq_pkg::DEPTH_DEF,
    parameter int PAYLOAD_BITS  = spq_pkg::PAYLOAD_BITS_DEF,
    parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [spq_pkg::CMD_W-1:0]       i_command,
    input  wire logic [spq_pkg::PAY_PORT_W-1:0]  i_payload,
    input  wire logic signed [spq_pkg::PRI_PORT_W-1:0] i_priority_req,
    input  wire logic                            i_cfg_we,
    input  wire logic [spq_pkg::CNT_W-1:0]       i_cfg_wdata,
    output logic                                 o_strobe,
    output logic [spq_pkg::PAY_PORT_W-1:0]       o_out_payload,
    output logic [spq_pkg::STAT_W-1:0]           o_status,
    output logic [spq_pkg::CNT_W-1:0]            o_item_count,
    output logic                                 o_is_empty,
    output logic                                 o_is_full
);
    import spq_pkg::*;

    logic [CNT_W-1:0]         r_limit;
    logic [CNT_W-1:0]         r_count, n_count;
    logic [CNT_W-1:0]         w_limit;
    logic                     w_accept;
    logic                     w_full;
    t_cell_ctrl               w_ctrl;
    t_status                  n_status;
    logic [PAYLOAD_BITS-1:0]  w_new_pay;
    logic [PRIORITY_BITS-1:0] w_new_pri;
    logic [PAYLOAD_BITS-1:0]  n_out_pay;

    logic                     w_ins [DEPTH];
    logic [PAYLOAD_BITS-1:0]  w_pay [DEPTH];
    logic [PRIORITY_BITS-1:0] w_pri [DEPTH];

    logic                     r_strobe;
    logic [PAYLOAD_BITS-1:0]  r_out_pay;
    t_status                  r_status;
    logic [CNT_W-1:0]         r_out_count;
    logic                     r_empty;
    logic                     r_full;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    // Request fields at storage width; priority zero-extended, then signed
    assign w_new_pay = PAYLOAD_BITS'(i_payload);
    assign w_new_pri = PRIORITY_BITS'($unsigned(i_priority_req));

    // Capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    // Limit saturates at the cell count
    assign w_limit = (int'(r_limit) > DEPTH) ? CNT_W'(DEPTH) : r_limit;
    assign w_full  = r_count >= w_limit;

    // Command decode
    always_comb begin
        w_ctrl    = '0;
        n_count   = r_count;
        n_status  = ST_OK;
        n_out_pay = '0;
        if (w_accept) begin
            case (t_cmd'(i_command))
                CMD_ENQUEUE: begin
                    if (w_full) begin
                        n_status = ST_FULL;
                    end else begin
                        w_ctrl.enq = 1'b1;
                        n_count    = r_count + 1'b1;
                    end
                end
                CMD_DEQUEUE: begin
                    if (r_count == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        w_ctrl.deq = 1'b1;
                        n_count    = r_count - 1'b1;
                        n_out_pay  = w_pay[0];
                    end
                end
                CMD_CLEAR: begin
                    n_count = '0;
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Row of cells, head at index 0
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                     w_prev_ins;
        logic [PAYLOAD_BITS-1:0]  w_prev_pay, w_next_pay;
        logic [PRIORITY_BITS-1:0] w_prev_pri, w_next_pri;

        if (g == 0) begin : g_head
            assign w_prev_ins = 1'b0;
            assign w_prev_pay = w_new_pay;
            assign w_prev_pri = w_new_pri;
        end else begin : g_body
            assign w_prev_ins = w_ins[g-1];
            assign w_prev_pay = w_pay[g-1];
            assign w_prev_pri = w_pri[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_next_pay = w_pay[g];
            assign w_next_pri = w_pri[g];
        end else begin : g_link
            assign w_next_pay = w_pay[g+1];
            assign w_next_pri = w_pri[g+1];
        end

        spq_cell #(
            .IDX           (g),
            .PAYLOAD_BITS  (PAYLOAD_BITS),
            .PRIORITY_BITS (PRIORITY_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (w_ctrl),
            .i_count    (r_count),
            .i_new_pay  (w_new_pay),
            .i_new_pri  (w_new_pri),
            .i_prev_ins (w_prev_ins),
            .i_prev_pay (w_prev_pay),
            .i_prev_pri (w_prev_pri),
            .i_next_pay (w_next_pay),
            .i_next_pri (w_next_pri),
            .o_ins      (w_ins[g]),
            .o_pay      (w_pay[g]),
            .o_pri      (w_pri[g])
        );
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_pay   <= n_out_pay;
            r_status    <= n_status;
            r_out_count <= n_count;
            r_empty     <= (n_count == '0);
            r_full      <= (n_count >= w_limit);
        end
    end

    assign o_strobe      = r_strobe;
    assign o_out_payload = PAY_PORT_W'(r_out_pay);
    assign o_status      = r_status;
    assign o_item_count  = r_out_count;
    assign o_is_empty    = r_empty;
    assign o_is_full     = r_full;

    // Checks
    `SPQ_ASSERT(a_reset_quiet, i_clk, !i_rst_n |=> !o_strobe)
    `SPQ_ASSERT_RST(a_strobe_follows_req, i_clk, i_rst_n, o_strobe == $past(w_accept))
    `SPQ_ASSERT_RST(a_count_in_range, i_clk, i_rst_n, int'(r_count) <= DEPTH)
    `SPQ_ASSERT_RST(a_enq_grows, i_clk, i_rst_n,
        i_rst_n && w_ctrl.enq |=> r_count == $past(r_count) + 1'b1)
    `SPQ_ASSERT_RST(a_refused_holds, i_clk, i_rst_n,
        i_rst_n && w_accept && n_status != ST_OK |=> r_count == $past(r_count))

endmodule

`default_nettype wire

/* rtl/spq_cell.sv */
`default_nettype none

module spq_cell #(
    parameter int IDX           = 0,
    parameter int PAYLOAD_BITS  = 32,
    parameter int PRIORITY_BITS = 16
) (
    input  wire logic                      i_clk,
    input  wire spq_pkg::t_cell_ctrl       i_ctrl,
    input  wire logic [spq_pkg::CNT_W-1:0] i_count,
    input  wire logic [PAYLOAD_BITS-1:0]   i_new_pay,
    input  wire logic [PRIORITY_BITS-1:0]  i_new_pri,
    input  wire logic                      i_prev_ins,
    input  wire logic [PAYLOAD_BITS-1:0]   i_prev_pay,
    input  wire logic [PRIORITY_BITS-1:0]  i_prev_pri,
    input  wire logic [PAYLOAD_BITS-1:0]   i_next_pay,
    input  wire logic [PRIORITY_BITS-1:0]  i_next_pri,
    output logic                           o_ins,
    output logic [PAYLOAD_BITS-1:0]        o_pay,
    output logic [PRIORITY_BITS-1:0]       o_pri
);
    import spq_pkg::*;

    logic [PAYLOAD_BITS-1:0]  r_pay, n_pay;
    logic [PRIORITY_BITS-1:0] r_pri, n_pri;
    logic                     w_occupied;

    // Insertion point: first held entry of strictly lower priority, or the tail
    assign w_occupied = int'(i_count) > IDX;
    assign o_ins = w_occupied ? ($signed(i_new_pri) > $signed(r_pri)) : 1'b1;

    // Take new request, the entry above, or the entry below
    always_comb begin
        n_pay = r_pay;
        n_pri = r_pri;
        if (i_ctrl.enq && o_ins) begin
            if (i_prev_ins) begin
                n_pay = i_prev_pay;
                n_pri = i_prev_pri;
            end else begin
                n_pay = i_new_pay;
                n_pri = i_new_pri;
            end
        end else if (i_ctrl.deq) begin
            n_pay = i_next_pay;
            n_pri = i_next_pri;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pay <= n_pay;
        r_pri <= n_pri;
    end

    assign o_pay = r_pay;
    assign o_pri = r_pri;

endmodule

`default_nettype wire
